/* design/cfsp_pkg.sv */
package cfsp_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [2:0] CMD_COLOR = 3'd1;
  localparam logic [2:0] CMD_QR = 3'd2;
  localparam logic [2:0] CMD_LOCATION = 3'd3;
  localparam logic [2:0] CMD_READY = 3'd5;
  localparam logic [7:0] VALID_MARK = 8'h01;

  localparam int PAYLOAD_KEPT = 4;
  localparam int PIDX_W = $clog2(PAYLOAD_KEPT);

  typedef struct packed {
    logic [2:0] cmd_id;
    logic       checksum_ok;
    logic [7:0] frame_length;
    logic [7:0] valid_byte;
    logic [7:0] value_a;
    logic [7:0] value_b;
    logic [7:0] value_c;
    logic       color_applied;
    logic       color_seen;
    logic       qr_seen;
  } result_t;

endpackage

/* design/cfsp_parser.sv */
module cfsp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              color_hold,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              res_ready,
  output logic              res_valid,
  output cfsp_pkg::result_t res
);
  import cfsp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CMDID,
    PH_LENGTH,
    PH_DATA,
    PH_CHECK
  } phase_t;

  phase_t     phase;
  logic       held;
  logic [7:0] held_byte;
  logic [7:0] running_sum;
  logic [7:0] byte_count;
  logic [7:0] frame_len;
  logic [2:0] frame_cmd;
  logic [7:0] payload [PAYLOAD_KEPT];
  logic       color_seen_flag;
  logic       qr_seen_flag;

  logic       advance;
  logic       ok;
  logic       applied;
  logic       color_seen_next;
  logic       qr_seen_next;
  logic [7:0] va;
  logic [7:0] vb;
  logic [7:0] vc;
  logic [7:0] count_inc;

  assign advance   = held && ((phase != PH_CHECK) || res_ready);
  assign in_ready  = !held || advance;
  assign res_valid = held && (phase == PH_CHECK);
  assign ok        = (held_byte == running_sum);
  assign count_inc = byte_count + 8'd1;

  always_comb begin
    va = '0;
    vb = '0;
    vc = '0;
    applied = 1'b0;
    color_seen_next = color_seen_flag;
    qr_seen_next = qr_seen_flag;
    case (frame_cmd)
      CMD_COLOR: begin
        va = payload[3];
        vb = payload[2];
        vc = payload[1];
        if (ok && !color_hold) begin
          applied = 1'b1;
          if ((payload[0] == VALID_MARK) || (payload[1] != '0) ||
              (payload[2] != '0) || (payload[3] != '0)) begin
            color_seen_next = 1'b1;
          end
        end
      end
      CMD_QR: begin
        va = payload[1];
        vb = payload[2];
        vc = payload[3];
        if (ok && (payload[0] == VALID_MARK)) begin
          qr_seen_next = 1'b1;
        end
      end
      CMD_LOCATION: begin
        va = payload[1];
        vb = payload[2];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.cmd_id        = frame_cmd;
    res.checksum_ok   = ok;
    res.frame_length  = frame_len;
    res.valid_byte    = payload[0];
    res.value_a       = va;
    res.value_b       = vb;
    res.value_c       = vc;
    res.color_applied = applied;
    res.color_seen    = color_seen_next;
    res.qr_seen       = qr_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      running_sum <= '0;
      byte_count <= '0;
      frame_len <= '0;
      frame_cmd <= '0;
      color_seen_flag <= 1'b0;
      qr_seen_flag <= 1'b0;
      for (int i = 0; i < PAYLOAD_KEPT; i++) begin
        payload[i] <= '0;
      end
    end else if (advance) begin
      case (phase)
        PH_HEADER: begin
          running_sum <= '0;
          byte_count <= '0;
          if (held_byte == HEADER_BYTE) begin
            phase <= PH_CMDID;
          end
        end
        PH_CMDID: begin
          if ((held_byte >= {5'd0, CMD_COLOR}) && (held_byte <= {5'd0, CMD_READY})) begin
            frame_cmd <= held_byte[2:0];
            running_sum <= running_sum + held_byte;
            phase <= PH_LENGTH;
          end else begin
            phase <= PH_HEADER;
            running_sum <= '0;
            byte_count <= '0;
          end
        end
        PH_LENGTH: begin
          frame_len <= held_byte;
          running_sum <= running_sum + held_byte;
          byte_count <= '0;
          phase <= (held_byte == '0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          if (byte_count < 8'(PAYLOAD_KEPT)) begin
            payload[byte_count[PIDX_W-1:0]] <= held_byte;
          end
          byte_count <= count_inc;
          running_sum <= running_sum + held_byte;
          if (count_inc == frame_len) begin
            phase <= PH_CHECK;
          end
        end
        PH_CHECK: begin
          color_seen_flag <= color_seen_next;
          qr_seen_flag <= qr_seen_next;
          phase <= PH_HEADER;
          running_sum <= '0;
          byte_count <= '0;
        end
        default: begin
          phase <= PH_HEADER;
          running_sum <= '0;
          byte_count <= '0;
        end
      endcase
    end
  end

endmodule

/* design/cfsp_out_reg.sv */
module cfsp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  output logic              res_ready,
  input  cfsp_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_ready,
  output cfsp_pkg::result_t out_res
);
  import cfsp_pkg::*;

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

endmodule

/* design/checksummed_serial_frame_parser.sv */
// Frame parser for a byte-wide serial link. Each slave-side word is one
// received byte. Frames are a 0xFF header, a command id from 1 to 5, a length
// byte, the payload and an 8-bit additive check byte. Only the check byte
// produces a master-side word, which carries the command, the check result,
// the length, the decoded payload fields and the sticky color and QR flags.
// The color_hold register is written through cfg_wr_en and cfg_wr_data; while
// it is set, good color frames are reported but not applied.
// A byte is taken into an input register, then processed against the parser
// state, and a result lands in the output register. The result word is
// therefore presented once its check byte has passed from the input register
// into the output register. One byte is accepted every cycle as long as the
// output register can drain, so the sustained rate is one byte per cycle.
// Reset clears the parser to header hunting, the payload store, the sticky
// flags and color_hold, and empties both registers. When the receiver stalls,
// the result waits in the output register; bytes that produce no result keep
// flowing, and a second check byte waits in the input register until the
// output register frees up.
module checksummed_serial_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // cmd_id, checksum_ok, frame_length, valid_byte,
                                 // value_a, value_b, value_c, color_applied,
                                 // color_seen, qr_seen, zero pad
);
  import cfsp_pkg::*;

  logic    color_hold;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_hold <= 1'b0;
    end else if (cfg_wr_en) begin
      color_hold <= cfg_wr_data;
    end
  end

  cfsp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .color_hold (color_hold),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  cfsp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {1'b0, out_res.qr_seen, out_res.color_seen, out_res.color_applied,
                    out_res.value_c, out_res.value_b, out_res.value_a,
                    out_res.valid_byte, out_res.frame_length, out_res.checksum_ok,
                    out_res.cmd_id};

endmodule
